// ===== src/sitda_pkg.sv =====
// Shared constants and types for the signed integer to decimal ASCII converter.
// No dependencies; used by sitda_dabble and the top level.
package sitda_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int DATA_BITS      = 64;
    localparam int CHAR_BITS      = 8;

    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'd48;

    // Status of the digit stream offered by the converter core.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [3:0] digit;
    } t_dig_stat;

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Signed two's-complement integer to decimal ASCII text, stream in, stream out.
// Uses the serial BCD core sitda_dabble and the constants of sitda_pkg.
//
// Slave side: one transaction carries one integer; the low VALUE_BITS bits of
// i_s_tdata are taken as a two's-complement value. o_s_tready is high only while
// no number is being converted or sent.
// Master side: one transaction per character, most significant first. A negative
// value starts with '-'; zero gives a single '0'; no leading zeros. o_m_tlast
// marks the final character of each number.
// Sequence: the core shifts in one magnitude bit per cycle, then removes one leading
// zero per cycle, then sends one digit per cycle while the output is not stalled.
// Leading zeros and digits always fill its NDIG positions (19 for 64 bits), and
// o_s_tready stays low until the final digit is loaded into the output register.
// A '-' enters the output register while the core converts and, without stalls,
// leaves during conversion; the first digit follows once leading zeros are removed.
// Reset and stalls: synchronous active-low reset empties the output register and
// returns both sides to idle. While i_m_tready is low the current character stays
// in the output register and the core waits. The next number is accepted while
// the final character of the previous one still waits.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [sitda_pkg::DATA_BITS-1:0]     i_s_tdata,  // [63:0] value
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [sitda_pkg::CHAR_BITS-1:0]     o_m_tdata,  // [7:0] char_code
    output logic                                o_m_tlast   // last_char
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                          r_state;
    logic                            r_minus;
    logic                            r_m_tvalid;
    logic [sitda_pkg::CHAR_BITS-1:0] r_m_tdata;
    logic                            r_m_tlast;

    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_neg;
    logic                  accept;
    logic                  load;
    logic                  dig_next;
    sitda_pkg::t_dig_stat  dig_stat;

    assign in_val = i_s_tdata[VALUE_BITS-1:0];
    assign in_neg = in_val[VALUE_BITS-1];
    // Taken as unsigned, so the most negative value negates to itself.
    assign in_mag = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign load       = !r_m_tvalid || i_m_tready;
    assign dig_next   = (r_state == ST_RUN) && load && !r_minus && dig_stat.valid;

    sitda_dabble #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mag   (in_mag),
        .i_next  (dig_next),
        .o_stat  (dig_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_minus    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (load) begin
                        r_m_tvalid <= 1'b0;
                    end
                    if (accept) begin
                        r_minus <= in_neg;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (load) begin
                        if (r_minus) begin
                            r_m_tdata  <= sitda_pkg::CH_MINUS;
                            r_m_tlast  <= 1'b0;
                            r_m_tvalid <= 1'b1;
                            r_minus    <= 1'b0;
                        end else if (dig_stat.valid) begin
                            r_m_tdata  <= sitda_pkg::CH_ZERO + {4'd0, dig_stat.digit};
                            r_m_tlast  <= dig_stat.last;
                            r_m_tvalid <= 1'b1;
                            if (dig_stat.last) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_m_tvalid <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

endmodule

// ===== src/sitda_dabble.sv =====
// Bit-serial binary to BCD core (shift and add three), with leading zero
// removal and a digit-at-a-time output. Depends on sitda_pkg.
module sitda_dabble #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic                  i_next,
    output sitda_pkg::t_dig_stat  o_stat
);

    // The magnitude is at most 2^(VALUE_BITS-1).
    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int BW     = $clog2(VALUE_BITS + 1);
    localparam int CW     = $clog2(NDIG + 1);
    localparam logic [BW-1:0] BITS_INIT = BW'(VALUE_BITS);
    localparam logic [CW-1:0] DIG_INIT  = CW'(NDIG);
    localparam logic [BW-1:0] BITS_ONE  = BW'(1);
    localparam logic [CW-1:0] DIG_ONE   = CW'(1);

    typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_TRIM, ST_SEND} t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BW-1:0]         r_bits;
    logic [CW-1:0]         r_cnt;
    logic [BCD_W-1:0]      adj;
    logic [3:0]            top_dig;

    // Each digit of five or more gets three added before the next doubling.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign top_dig       = r_bcd[BCD_W-1 -: 4];
    assign o_stat.valid  = (r_state == ST_SEND);
    assign o_stat.last   = (r_cnt == DIG_ONE);
    assign o_stat.digit  = top_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_mag   <= i_mag;
                        r_bcd   <= '0;
                        r_bits  <= BITS_INIT;
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_bcd  <= {adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
                    r_mag  <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    r_bits <= r_bits - BITS_ONE;
                    if (r_bits == BITS_ONE) begin
                        r_cnt   <= DIG_INIT;
                        r_state <= ST_TRIM;
                    end
                end
                ST_TRIM: begin
                    // Drop leading zeros, but always keep the units digit.
                    if (top_dig == 4'd0 && r_cnt > DIG_ONE) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_cnt <= r_cnt - DIG_ONE;
                    end else begin
                        r_state <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (i_next) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_cnt <= r_cnt - DIG_ONE;
                        if (r_cnt == DIG_ONE) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
